// ===== hw/rtl/novelty_table_filter_defines.svh =====
// ----------------------------------------------------------------------------
// Novelty table filter assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef NOVELTY_TABLE_FILTER_DEFINES_SVH
`define NOVELTY_TABLE_FILTER_DEFINES_SVH

// same-cycle implication
`define NTF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NTF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ntf_pkg.sv =====
// ----------------------------------------------------------------------------
// Novelty table filter package
// Sizes, memory geometry, command codes and control state type.
// ----------------------------------------------------------------------------
package ntf_pkg;

  localparam int STATE_BYTES = 128;
  localparam int VALUE_COUNT = 256;

  localparam int MODE_W = 2;
  localparam int POS_W  = 7;
  localparam int VAL_W  = 8;

  localparam logic [MODE_W-1:0] MODE_CHECK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RECORD = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

  // seen-value table: one bit per (position, value), packed into words
  localparam int VS_WORD  = 32;
  localparam int VS_BW    = $clog2(VS_WORD);
  localparam int FLAT_W   = $clog2(STATE_BYTES * VALUE_COUNT) > VS_BW ?
                            $clog2(STATE_BYTES * VALUE_COUNT) : VS_BW + 1;
  localparam int VS_DEPTH = (STATE_BYTES * VALUE_COUNT + VS_WORD - 1) / VS_WORD;
  localparam int VS_AW    = VS_DEPTH > 1 ? $clog2(VS_DEPTH) : 1;

  // seen-bit table: {seen as one, seen as zero} per position
  localparam int BS_WORD  = 2 * VAL_W;
  localparam int BS_DEPTH = STATE_BYTES;
  localparam int BS_AW    = BS_DEPTH > 1 ? $clog2(BS_DEPTH) : 1;

  localparam int CLR_LEN  = VS_DEPTH > BS_DEPTH ? VS_DEPTH : BS_DEPTH;
  localparam int CLR_W    = CLR_LEN > 1 ? $clog2(CLR_LEN) : 1;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_t;

endpackage

// ===== hw/rtl/ntf_ram.sv =====
// ----------------------------------------------------------------------------
// Novelty table filter RAM
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ntf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/novelty_table_filter.sv =====
// ----------------------------------------------------------------------------
// Novelty table filter
// Width-one novelty check, record and clear over byte-serial machine states.
// ----------------------------------------------------------------------------
// Check and record beats are taken one per cycle unless the stage is stalled
// or clearing; each reads one word of the seen-value RAM (VS_DEPTH x 32) and
// the seen-bit RAM (128 x 16) on accept, and a record beat writes the updated
// word back from the read-modify-write stage, with a one-entry bypass covering
// the back-to-back case on the same word. A check beat marked last stalls the
// input only while the previous novel result is still held at the output.
// A clear beat, and reset, start a sweep zeroing both RAMs one word per cycle;
// no input beat is taken during the sweep, configuration writes still are.
module novelty_table_filter
  import ntf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [MODE_W-1:0] mode,
  input  logic [POS_W-1:0]  position,
  input  logic [VAL_W-1:0]  byte_value,
  input  logic              last,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              novel
);

`include "novelty_table_filter_defines.svh"

  state_t state, state_next;
  logic [CLR_W-1:0] clr_cnt;
  logic clr_done;

  logic bit_mode;
  logic novel_so_far;

  logic in_fire;
  logic [FLAT_W-1:0] in_flat;
  logic in_pos_ok, in_val_ok;

  logic              s1_valid;
  logic [MODE_W-1:0] s1_mode;
  logic              s1_pos_ok, s1_val_ok, s1_last;
  logic [VAL_W-1:0]  s1_val;
  logic [VS_AW-1:0]  s1_vaddr;
  logic [VS_BW-1:0]  s1_vbit;
  logic [BS_AW-1:0]  s1_baddr;
  logic s1_result, s1_stall, s1_fire, s1_clear;

  logic [VS_WORD-1:0] v_rdata, v_word, v_new;
  logic [BS_WORD-1:0] b_rdata, b_word, b_new;
  logic [VAL_W-1:0]   seen_one, seen_zero;
  logic v_wr, b_wr, hit;

  logic               fwd_v_valid, fwd_b_valid;
  logic [VS_AW-1:0]   fwd_v_addr;
  logic [BS_AW-1:0]   fwd_b_addr;
  logic [VS_WORD-1:0] fwd_v_data;
  logic [BS_WORD-1:0] fwd_b_data;

  logic               vram_we, bram_we;
  logic [VS_AW-1:0]   vram_waddr;
  logic [BS_AW-1:0]   bram_waddr;
  logic [VS_WORD-1:0] vram_wdata;
  logic [BS_WORD-1:0] bram_wdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_mode <= 1'b0;
    end else if (cfg_valid) begin
      bit_mode <= cfg_data;
    end
  end

  // input side
  assign in_pos_ok = 32'(position) < 32'(STATE_BYTES);
  assign in_val_ok = 32'(byte_value) < 32'(VALUE_COUNT);
  assign in_flat   = FLAT_W'(position) * FLAT_W'(VALUE_COUNT) + FLAT_W'(byte_value);
  assign in_ready  = (state == ST_RUN) && !(s1_valid && (s1_stall || s1_clear));
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode   <= mode;
      s1_pos_ok <= in_pos_ok;
      s1_val_ok <= in_val_ok;
      s1_last   <= last;
      s1_val    <= byte_value;
      s1_vaddr  <= VS_AW'(in_flat >> VS_BW);
      s1_vbit   <= in_flat[VS_BW-1:0];
      s1_baddr  <= BS_AW'(position);
    end
  end

  // read-modify-write stage
  assign v_word    = (fwd_v_valid && fwd_v_addr == s1_vaddr) ? fwd_v_data : v_rdata;
  assign b_word    = (fwd_b_valid && fwd_b_addr == s1_baddr) ? fwd_b_data : b_rdata;
  assign seen_one  = b_word[BS_WORD-1:VAL_W];
  assign seen_zero = b_word[VAL_W-1:0];

  assign s1_clear  = s1_mode == MODE_CLEAR;
  assign s1_result = s1_valid && s1_mode == MODE_CHECK && s1_last;
  assign s1_stall  = s1_result && out_valid && !out_ready;
  assign s1_fire   = s1_valid && !s1_stall;

  always_comb begin
    hit = 1'b0;
    if (s1_pos_ok) begin
      if (bit_mode) begin
        hit = |((~seen_one & s1_val) | (~seen_zero & ~s1_val));
      end else if (s1_val_ok) begin
        hit = !v_word[s1_vbit];
      end
    end
  end

  assign v_new = v_word | (VS_WORD'(1) << s1_vbit);
  assign b_new = {seen_one | s1_val, seen_zero | ~s1_val};
  assign v_wr  = s1_fire && s1_mode == MODE_RECORD && s1_pos_ok && s1_val_ok && !bit_mode;
  assign b_wr  = s1_fire && s1_mode == MODE_RECORD && s1_pos_ok && bit_mode;

  // bypass for a read issued on the edge of the write to the same word
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_v_valid <= 1'b0;
      fwd_b_valid <= 1'b0;
    end else if (state == ST_CLEAR || (s1_fire && s1_clear)) begin
      fwd_v_valid <= 1'b0;
      fwd_b_valid <= 1'b0;
    end else if (s1_fire) begin
      fwd_v_valid <= v_wr;
      fwd_b_valid <= b_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      fwd_v_addr <= s1_vaddr;
      fwd_v_data <= v_new;
      fwd_b_addr <= s1_baddr;
      fwd_b_data <= b_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      novel_so_far <= 1'b0;
    end else if (s1_fire && s1_clear) begin
      novel_so_far <= 1'b0;
    end else if (s1_fire && s1_mode == MODE_CHECK) begin
      novel_so_far <= s1_last ? 1'b0 : (novel_so_far | hit);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_result) begin
      novel <= novel_so_far | hit;
    end
  end

  // clear sweep control
  assign clr_done = clr_cnt == CLR_W'(CLR_LEN - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_done) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (s1_fire && s1_clear) begin
          state_next = ST_CLEAR;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (state == ST_CLEAR) begin
      clr_cnt <= clr_done ? '0 : clr_cnt + 1'b1;
    end else begin
      clr_cnt <= '0;
    end
  end

  // memory write ports
  always_comb begin
    if (state == ST_CLEAR) begin
      vram_we    = 32'(clr_cnt) < 32'(VS_DEPTH);
      vram_waddr = VS_AW'(clr_cnt);
      vram_wdata = '0;
      bram_we    = 32'(clr_cnt) < 32'(BS_DEPTH);
      bram_waddr = BS_AW'(clr_cnt);
      bram_wdata = '0;
    end else begin
      vram_we    = v_wr;
      vram_waddr = s1_vaddr;
      vram_wdata = v_new;
      bram_we    = b_wr;
      bram_waddr = s1_baddr;
      bram_wdata = b_new;
    end
  end

  ntf_ram #(
    .WIDTH (VS_WORD),
    .DEPTH (VS_DEPTH),
    .AW    (VS_AW)
  ) u_value_ram (
    .clk   (clk),
    .we    (vram_we),
    .waddr (vram_waddr),
    .wdata (vram_wdata),
    .re    (in_fire),
    .raddr (VS_AW'(in_flat >> VS_BW)),
    .rdata (v_rdata)
  );

  ntf_ram #(
    .WIDTH (BS_WORD),
    .DEPTH (BS_DEPTH),
    .AW    (BS_AW)
  ) u_bit_ram (
    .clk   (clk),
    .we    (bram_we),
    .waddr (bram_waddr),
    .wdata (bram_wdata),
    .re    (in_fire),
    .raddr (BS_AW'(position)),
    .rdata (b_rdata)
  );

  `NTF_ASSERT_NOW(a_stall_blocks_input, s1_stall, !in_ready, "beat taken while stage stalled")
  `NTF_ASSERT_NOW(a_sweep_stage_empty, state == ST_CLEAR, !s1_valid && !in_ready, "beat during sweep")
  `NTF_ASSERT_NEXT(a_clear_starts_sweep, s1_fire && s1_clear, state == ST_CLEAR && !s1_valid, "clear did not start sweep")
  `NTF_ASSERT_NEXT(a_result_presented, s1_fire && s1_result, out_valid, "result beat lost")

endmodule
